/* hw/rtl/nthrb_pkg.sv */
// nthrb_pkg: field widths, constants and the sequencer state type for the
// n-th root bisection block. No dependencies.
package nthrb_pkg;

    localparam int RADICAND_W = 32;
    localparam int EXPONENT_W = 5;
    localparam int ROOT_W     = 32;
    localparam int TOL_W      = 16;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

    // operand slice width of the shared multiplier
    localparam int MUL_CHUNK = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MID,
        S_MUL,
        S_NORM,
        S_CMP
    } t_state;

endpackage

/* hw/rtl/nth_root_bisection.sv */
// nth_root_bisection: unsigned fixed-point n-th root by bisection, one shared
// multiplier under a small sequencer. Depends on nthrb_pkg.
//
//  channel   direction  handshake                       payload
//  -------   ---------  ------------------------------  ---------------------------
//  command   in         i_start & !o_busy               i_radicand, i_exponent
//  result    out        o_valid, one-cycle strobe       o_root_value
//  config    in         i_cfg_valid & o_cfg_ready       i_cfg_data (tolerance)
//
// A zero radicand answers in the next cycle. Otherwise each bisection step runs a
// midpoint state, then for each of n multiplications (n the clipped exponent) a
// multiply state per slice and a normalise state, then a compare state; NCHUNK =
// ceil(VALUE_BITS / 32) slices of the midpoint pass through the shared multiplier, and
// a saturated power cuts its step short. A further midpoint state closes a search on
// the tolerance. Defaults: about 26 steps. Synchronous reset leaves tolerance at 66.
// The result strobe cannot be stalled; a new command is taken from the strobe cycle on.
module nth_root_bisection #(
    parameter int FRAC_BITS    = 16,
    parameter int VALUE_BITS   = 32,
    parameter int MAX_EXPONENT = 31
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [nthrb_pkg::RADICAND_W-1:0]   i_radicand,
    input  logic [nthrb_pkg::EXPONENT_W-1:0]   i_exponent,
    output logic                               o_valid,
    output logic [nthrb_pkg::ROOT_W-1:0]       o_root_value,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [nthrb_pkg::TOL_W-1:0]        i_cfg_data
);

    localparam int VB     = VALUE_BITS;
    localparam int NCHUNK = (VB + nthrb_pkg::MUL_CHUNK - 1) / nthrb_pkg::MUL_CHUNK;
    localparam int PAD_W  = NCHUNK * nthrb_pkg::MUL_CHUNK;
    localparam int ACC_W  = VB + PAD_W;
    localparam int PART_W = VB + nthrb_pkg::MUL_CHUNK;
    localparam int CHK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int CNT_W  = (MAX_EXPONENT > 1) ? $clog2(MAX_EXPONENT + 1) : 1;
    localparam int SHF_W  = $clog2(PAD_W + 1);

    localparam logic [VB-1:0]    FIX_ONE  = VB'(1) << FRAC_BITS;
    localparam logic [CHK_W-1:0] CHK_LAST = CHK_W'(NCHUNK - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_EXPONENT);

    nthrb_pkg::t_state r_state, n_state;

    logic [nthrb_pkg::TOL_W-1:0]  r_tol;
    logic [VB-1:0]                r_x, n_x;
    logic [VB-1:0]                r_lo, n_lo;
    logic [VB-1:0]                r_hi, n_hi;
    logic [VB-1:0]                r_mid, n_mid;
    logic [VB-1:0]                r_p, n_p;
    logic                         r_sat, n_sat;
    logic [ACC_W-1:0]             r_acc, n_acc;
    logic [CNT_W-1:0]             r_n, n_n;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [CHK_W-1:0]             r_chk, n_chk;
    logic                         r_valid, n_valid;
    logic [nthrb_pkg::ROOT_W-1:0] r_root, n_root;

    logic [VB-1:0]                     x_in;
    logic [VB:0]                       lo_hi_sum;
    logic [VB-1:0]                     half_span;
    logic [VB-1:0]                     tol_ext;
    logic                              keep_going;
    logic [PAD_W-1:0]                  mid_pad;
    logic [nthrb_pkg::MUL_CHUNK-1:0]   mid_slice;
    logic [PART_W-1:0]                 partial;
    logic [SHF_W-1:0]                  part_shift;
    logic [ACC_W-1:0]                  part_ext;
    logic                              pow_ovf;

    // datapath helpers
    always_comb begin
        x_in       = VB'(i_radicand);
        lo_hi_sum  = {1'b0, r_lo} + {1'b0, r_hi};
        half_span  = (r_hi - r_lo) >> 1;
        tol_ext    = (r_tol == '0) ? VB'(1) : VB'(r_tol);
        keep_going = (half_span >= tol_ext);
        mid_pad    = PAD_W'(r_mid);
        mid_slice  = mid_pad[r_chk * nthrb_pkg::MUL_CHUNK +: nthrb_pkg::MUL_CHUNK];
        partial    = PART_W'(r_p) * PART_W'(mid_slice);
        part_shift = SHF_W'(r_chk) << $clog2(nthrb_pkg::MUL_CHUNK);
        part_ext   = ACC_W'(partial) << part_shift;
        // anything above VALUE_BITS after the fraction shift is an overflow
        pow_ovf    = |r_acc[ACC_W-1:FRAC_BITS+VB];
    end

    // next state and next datapath values
    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_p     = r_p;
        n_sat   = r_sat;
        n_acc   = r_acc;
        n_n     = r_n;
        n_cnt   = r_cnt;
        n_chk   = r_chk;
        n_valid = 1'b0;
        n_root  = r_root;

        case (r_state)
            nthrb_pkg::S_IDLE: begin
                if (i_start) begin
                    n_x  = x_in;
                    n_lo = '0;
                    n_hi = (x_in > FIX_ONE) ? x_in : FIX_ONE;
                    if (32'(i_exponent) > MAX_EXPONENT) begin
                        n_n = CNT_MAX;
                    end else begin
                        n_n = CNT_W'(i_exponent);
                    end
                    if (x_in == '0) begin
                        n_valid = 1'b1;
                        n_root  = '0;
                    end else begin
                        n_state = nthrb_pkg::S_MID;
                    end
                end
            end
            nthrb_pkg::S_MID: begin
                n_mid = lo_hi_sum[VB:1];
                if (keep_going) begin
                    n_p   = FIX_ONE;
                    n_sat = 1'b0;
                    n_cnt = r_n;
                    n_chk = '0;
                    n_state = (r_n == '0) ? nthrb_pkg::S_CMP : nthrb_pkg::S_MUL;
                end else begin
                    n_valid = 1'b1;
                    n_root  = nthrb_pkg::ROOT_W'(lo_hi_sum[VB:1]);
                    n_state = nthrb_pkg::S_IDLE;
                end
            end
            nthrb_pkg::S_MUL: begin
                n_acc = ((r_chk == '0) ? '0 : r_acc) + part_ext;
                if (r_chk == CHK_LAST) begin
                    n_state = nthrb_pkg::S_NORM;
                end else begin
                    n_chk = r_chk + CHK_W'(1);
                end
            end
            nthrb_pkg::S_NORM: begin
                if (pow_ovf) begin
                    n_sat   = 1'b1;
                    n_state = nthrb_pkg::S_CMP;
                end else begin
                    n_p   = r_acc[FRAC_BITS +: VB];
                    n_cnt = r_cnt - CNT_W'(1);
                    n_chk = '0;
                    n_state = (r_cnt == CNT_W'(1)) ? nthrb_pkg::S_CMP : nthrb_pkg::S_MUL;
                end
            end
            nthrb_pkg::S_CMP: begin
                if (r_sat || (r_p > r_x)) begin
                    n_hi    = r_mid;
                    n_state = nthrb_pkg::S_MID;
                end else if (r_p < r_x) begin
                    n_lo    = r_mid;
                    n_state = nthrb_pkg::S_MID;
                end else begin
                    // exact match ends the search
                    n_valid = 1'b1;
                    n_root  = nthrb_pkg::ROOT_W'(r_mid);
                    n_state = nthrb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nthrb_pkg::S_IDLE;
            end
        endcase
    end

    // port outputs
    always_comb begin
        o_busy       = (r_state != nthrb_pkg::S_IDLE);
        o_cfg_ready  = (r_state == nthrb_pkg::S_IDLE);
        o_valid      = r_valid;
        o_root_value = r_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nthrb_pkg::S_IDLE;
            r_valid <= 1'b0;
            r_tol   <= nthrb_pkg::TOL_RESET;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tol <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_p    <= n_p;
        r_sat  <= n_sat;
        r_acc  <= n_acc;
        r_n    <= n_n;
        r_cnt  <= n_cnt;
        r_chk  <= n_chk;
        r_root <= n_root;
    end

endmodule

/* sim/tb.sv */
// tb: self-checking testbench for nth_root_bisection, random and directed root commands
// against a bisection predictor held in a small scoreboard class.
// Depends on nthrb_pkg and nth_root_bisection.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS    = 16;
    localparam int VALUE_BITS   = 32;
    localparam int MAX_EXPONENT = 31;
    localparam int PHASE_ITEMS  = 150;
    localparam int TAIL_CYCLES  = 2200;
    localparam longint CYCLE_LIMIT = 64'd8_000_000;

    class root_scoreboard;
        logic [nthrb_pkg::ROOT_W-1:0] root_q[$];
        logic [nthrb_pkg::TOL_W-1:0]  tolerance = nthrb_pkg::TOL_RESET;
        int                           errors = 0;

        // fixed-point power with saturation on overflow beyond VALUE_BITS
        function automatic logic [63:0] fixed_pow(logic [63:0] base, int unsigned n,
                                                   output bit sat);
            logic [63:0] p;
            logic [63:0] prod;
            p   = 64'd1 << FRAC_BITS;
            sat = 1'b0;
            for (int unsigned i = 0; i < n; i++) begin
                prod = (p * base) >> FRAC_BITS;
                if (prod > ((64'd1 << VALUE_BITS) - 1)) begin
                    sat = 1'b1;
                    return (64'd1 << VALUE_BITS) - 1;
                end
                p = prod;
            end
            return p;
        endfunction

        function automatic logic [nthrb_pkg::ROOT_W-1:0] bisect_root(
                logic [nthrb_pkg::RADICAND_W-1:0] rad,
                logic [nthrb_pkg::EXPONENT_W-1:0] ex);
            logic [63:0] x, lo, hi, mid, p, tol;
            int unsigned n;
            bit sat;
            x   = 64'(rad);
            n   = (ex > MAX_EXPONENT) ? MAX_EXPONENT : ex;
            tol = (tolerance == '0) ? 64'd1 : 64'(tolerance);
            if (x == 0)
                return '0;
            lo  = 0;
            hi  = (x > (64'd1 << FRAC_BITS)) ? x : (64'd1 << FRAC_BITS);
            mid = (lo + hi) >> 1;
            while (mid - lo >= tol) begin
                p = fixed_pow(mid, n, sat);
                if (sat || p > x)
                    hi = mid;
                else if (p < x)
                    lo = mid;
                else
                    break;
                mid = (lo + hi) >> 1;
            end
            return mid[nthrb_pkg::ROOT_W-1:0];
        endfunction

        function void note_command(logic [nthrb_pkg::RADICAND_W-1:0] rad,
                                   logic [nthrb_pkg::EXPONENT_W-1:0] ex);
            root_q.push_back(bisect_root(rad, ex));
        endfunction

        function void check_root(logic [nthrb_pkg::ROOT_W-1:0] actual);
            logic [nthrb_pkg::ROOT_W-1:0] expected;
            if (root_q.size() == 0) begin
                $error("root_value: unexpected result, actual %0h", actual);
                errors++;
                return;
            end
            expected = root_q.pop_front();
            if (actual !== expected) begin
                $error("root_value mismatch: expected %0h, actual %0h", expected, actual);
                errors++;
            end
        endfunction

        function int pending();
            return root_q.size();
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_start;
    logic                             o_busy;
    logic [nthrb_pkg::RADICAND_W-1:0] i_radicand;
    logic [nthrb_pkg::EXPONENT_W-1:0] i_exponent;
    logic                             o_valid;
    logic [nthrb_pkg::ROOT_W-1:0]     o_root_value;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [nthrb_pkg::TOL_W-1:0]      i_cfg_data;

    root_scoreboard sb = new;
    longint         cycles = 0;
    bit             no_idle = 1'b0;

    nth_root_bisection #(
        .FRAC_BITS    (FRAC_BITS),
        .VALUE_BITS   (VALUE_BITS),
        .MAX_EXPONENT (MAX_EXPONENT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_radicand   (i_radicand),
        .i_exponent   (i_exponent),
        .o_valid      (o_valid),
        .o_root_value (o_root_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_root(o_root_value);
    end

    // called at a falling edge, returns at a falling edge with start still high
    task automatic send_command(input logic [nthrb_pkg::RADICAND_W-1:0] rad,
                                input logic [nthrb_pkg::EXPONENT_W-1:0] ex);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start    = 1'b1;
        i_radicand = rad;
        i_exponent = ex;
        do @(posedge i_clk); while (o_busy);
        sb.note_command(rad, ex);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_tolerance(input logic [nthrb_pkg::TOL_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.tolerance = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_command();
        logic [nthrb_pkg::RADICAND_W-1:0] rad;
        logic [nthrb_pkg::EXPONENT_W-1:0] ex;
        logic [63:0]                      p;
        bit                               sat;
        ex = nthrb_pkg::EXPONENT_W'($urandom_range(0, 31));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: rad = $urandom;
            4, 5:       rad = nthrb_pkg::RADICAND_W'($urandom_range(0, 32'h0001_ffff));
            6:          rad = nthrb_pkg::RADICAND_W'($urandom_range(0, 255));
            7, 8: begin
                // power of a short root so that an exact hit is possible
                p   = sb.fixed_pow(64'($urandom_range(1, 8)) << (FRAC_BITS - 2), ex, sat);
                rad = sat ? $urandom : p[nthrb_pkg::RADICAND_W-1:0];
            end
            default:    rad = 32'hffff_ffff - nthrb_pkg::RADICAND_W'($urandom_range(0, 255));
        endcase
        send_command(rad, ex);
    endtask

    logic [nthrb_pkg::TOL_W-1:0] phase_tol[4];

    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_radicand  = '0;
        i_exponent  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero radicand, exponent extremes, exact hits, zero exponent, saturation
        send_command(32'h0000_0000, 5'd0);
        send_command(32'h0000_0000, 5'd31);
        send_command(32'h0000_0001, 5'd0);
        send_command(32'h0000_0001, 5'd31);
        send_command(32'h0001_0000, 5'd0);
        send_command(32'h0000_8000, 5'd0);
        send_command(32'h0020_0000, 5'd0);
        send_command(32'h0004_0000, 5'd2);
        send_command(32'h0001_0000, 5'd1);
        send_command(32'h0001_0000, 5'd31);
        send_command(32'h0008_0000, 5'd3);
        send_command(32'h0010_0000, 5'd4);
        send_command(32'hffff_ffff, 5'd0);
        send_command(32'hffff_ffff, 5'd1);
        send_command(32'hffff_ffff, 5'd2);
        send_command(32'hffff_ffff, 5'd31);
        send_command(32'h8000_0000, 5'd16);
        send_command(32'h0000_ffff, 5'd7);
        send_command(32'h5555_5555, 5'd10);
        send_command(32'haaaa_aaaa, 5'd21);
        drain();

        phase_tol[0] = 16'd1;
        phase_tol[1] = 16'hffff;
        phase_tol[2] = 16'd0;
        phase_tol[3] = nthrb_pkg::TOL_W'($urandom_range(2, 16'hfffe));

        for (int ph = 0; ph < 5; ph++) begin
            if (ph != 0)
                write_tolerance(phase_tol[ph-1]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // bursts with no idle gaps now and then
                if (k % 40 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                random_command();
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("root_value: %0d results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
